// ----- rtl/core/fpv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_pkg: shared widths and stage type for the velocity pipeline
// Holds the fixed-point format, the derived datapath widths and the record
// that travels down the pipeline with each request.
// ----------------------------------------------------------------------------
package fpv_pkg;

    // Format of the fields.
    localparam int COORD_BITS = 7;
    localparam int FRAC_BITS  = 16;
    localparam int SPEED_BITS = 8;
    localparam int VEL_BITS   = 18;
    localparam int START_BITS = COORD_BITS + FRAC_BITS;

    // Squared distance, and the radicand padded to an even bit count.
    localparam int SQ_BITS   = 2 * COORD_BITS + 1;
    localparam int RAD_BITS  = SQ_BITS + FRAC_BITS + ((SQ_BITS + FRAC_BITS) % 2);
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int SREM_BITS = ROOT_BITS + 2;

    // Scaled numerator and quotient; the quotient stays below speed times
    // the square root of the fraction scale, with one bit of margin.
    localparam int NUM_BITS  = COORD_BITS + FRAC_BITS + SPEED_BITS;
    localparam int QUO_BITS  = SPEED_BITS + FRAC_BITS / 2 + 1;
    localparam int DREM_BITS = ROOT_BITS + 1;

    // Front stage, one stage per root bit, one stage per quotient bit.
    localparam int NSTAGE = 1 + ROOT_BITS + QUO_BITS;

    // Everything one request carries between stages.
    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic                  negx;
        logic                  negy;
        logic                  zero;
        logic [RAD_BITS-1:0]   rad;
        logic [SREM_BITS-1:0]  srem;
        logic [ROOT_BITS-1:0]  root;
        logic [NUM_BITS-1:0]   nx;
        logic [NUM_BITS-1:0]   ny;
        logic [DREM_BITS-1:0]  rx;
        logic [DREM_BITS-1:0]  ry;
        logic [QUO_BITS-1:0]   qx;
        logic [QUO_BITS-1:0]   qy;
    } t_stage;

endpackage

// ----- rtl/core/fpv_sqrt_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_sqrt_step: one digit of the integer square root
// Brings down the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module fpv_sqrt_step
    import fpv_pkg::*;
(
    input  t_stage i_st,
    output t_stage o_st
);

    // Trial subtract of 4*root + 1 from the shifted remainder.
    always_comb begin
        logic [SREM_BITS-1:0] rem_sh;
        logic [SREM_BITS-1:0] trial;
        rem_sh = {i_st.srem[SREM_BITS-3:0], i_st.rad[RAD_BITS-1:RAD_BITS-2]};
        trial  = {i_st.root, 2'b01};
        o_st     = i_st;
        o_st.rad = i_st.rad << 2;
        if (rem_sh >= trial) begin
            o_st.srem = rem_sh - trial;
            o_st.root = {i_st.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            o_st.srem = rem_sh;
            o_st.root = {i_st.root[ROOT_BITS-2:0], 1'b0};
        end
    end

endmodule

// ----- rtl/core/fpv_div_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpv_div_step: one quotient bit for both velocity components
// Restoring division of each scaled numerator by the magnitude.
// ----------------------------------------------------------------------------
module fpv_div_step
    import fpv_pkg::*;
(
    input  t_stage i_st,
    output t_stage o_st
);

    // Both components divide by the same magnitude in parallel.
    always_comb begin
        logic [DREM_BITS-1:0] shx;
        logic [DREM_BITS-1:0] shy;
        logic [DREM_BITS-1:0] den;
        shx = {i_st.rx[DREM_BITS-2:0], i_st.nx[NUM_BITS-1]};
        shy = {i_st.ry[DREM_BITS-2:0], i_st.ny[NUM_BITS-1]};
        den = {1'b0, i_st.root};
        o_st    = i_st;
        o_st.nx = i_st.nx << 1;
        o_st.ny = i_st.ny << 1;
        if (shx >= den) begin
            o_st.rx = shx - den;
            o_st.qx = {i_st.qx[QUO_BITS-2:0], 1'b1};
        end else begin
            o_st.rx = shx;
            o_st.qx = {i_st.qx[QUO_BITS-2:0], 1'b0};
        end
        if (shy >= den) begin
            o_st.ry = shy - den;
            o_st.qy = {i_st.qy[QUO_BITS-2:0], 1'b1};
        end else begin
            o_st.ry = shy;
            o_st.qy = {i_st.qy[QUO_BITS-2:0], 1'b0};
        end
    end

endmodule

// ----- rtl/core/fixed_point_velocity_from_target_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_velocity_from_target_top: launch position and scaled velocity
// The block accepts one request per clock while o_stall is low; each result
// passes one front stage for the deltas and squares, 16 square-root stages
// (one root bit each), 17 division stages (one quotient bit each, both
// components side by side) and the output register. Each stage holds only
// when it is full and the stage after it cannot take its data, so bubbles
// are squeezed out and requests keep entering while a result waits.
// ----------------------------------------------------------------------------
module fixed_point_velocity_from_target_top
    import fpv_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [COORD_BITS-1:0]        i_source_x,
    input  logic [COORD_BITS-1:0]        i_source_y,
    input  logic [COORD_BITS-1:0]        i_target_x,
    input  logic [COORD_BITS-1:0]        i_target_y,
    input  logic [SPEED_BITS-1:0]        i_speed,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [START_BITS-1:0]        o_start_x_fixed,
    output logic [START_BITS-1:0]        o_start_y_fixed,
    output logic signed [VEL_BITS-1:0]   o_velocity_x,
    output logic signed [VEL_BITS-1:0]   o_velocity_y
);

    t_stage              r_st [NSTAGE];
    t_stage              n_st [NSTAGE];
    logic [NSTAGE-1:0]   r_v;
    logic [NSTAGE:0]     can;

    // Stage loads when empty or when its successor loads.
    always_comb begin
        can[NSTAGE] = !o_valid || !i_stall;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            can[k] = !r_v[k] || can[k+1];
        end
    end
    assign o_stall = !can[0];

    // Front stage: deltas, squared distance and scaled numerators.
    always_comb begin
        logic [COORD_BITS-1:0]            adx;
        logic [COORD_BITS-1:0]            ady;
        logic [SQ_BITS-1:0]               d2;
        logic [COORD_BITS+SPEED_BITS-1:0] px;
        logic [COORD_BITS+SPEED_BITS-1:0] py;
        logic [NUM_BITS-1:0]              numx;
        logic [NUM_BITS-1:0]              numy;
        adx  = (i_target_x >= i_source_x) ? (i_target_x - i_source_x)
                                          : (i_source_x - i_target_x);
        ady  = (i_target_y >= i_source_y) ? (i_target_y - i_source_y)
                                          : (i_source_y - i_target_y);
        d2   = SQ_BITS'(adx) * SQ_BITS'(adx) + SQ_BITS'(ady) * SQ_BITS'(ady);
        px   = (COORD_BITS+SPEED_BITS)'(adx) * (COORD_BITS+SPEED_BITS)'(i_speed);
        py   = (COORD_BITS+SPEED_BITS)'(ady) * (COORD_BITS+SPEED_BITS)'(i_speed);
        numx = NUM_BITS'(px) << FRAC_BITS;
        numy = NUM_BITS'(py) << FRAC_BITS;
        n_st[0]      = '0;
        n_st[0].sx   = i_source_x;
        n_st[0].sy   = i_source_y;
        n_st[0].negx = i_target_x < i_source_x;
        n_st[0].negy = i_target_y < i_source_y;
        n_st[0].zero = (adx == '0) && (ady == '0);
        n_st[0].rad  = RAD_BITS'(d2) << FRAC_BITS;
        n_st[0].rx   = DREM_BITS'(numx >> QUO_BITS);
        n_st[0].ry   = DREM_BITS'(numy >> QUO_BITS);
        n_st[0].nx   = numx << (NUM_BITS - QUO_BITS);
        n_st[0].ny   = numy << (NUM_BITS - QUO_BITS);
    end

    // Square-root stages, then division stages.
    for (genvar k = 1; k <= ROOT_BITS; k++) begin : g_sqrt
        fpv_sqrt_step u_step (.i_st(r_st[k-1]), .o_st(n_st[k]));
    end
    for (genvar k = ROOT_BITS + 1; k < NSTAGE; k++) begin : g_div
        fpv_div_step u_step (.i_st(r_st[k-1]), .o_st(n_st[k]));
    end

    // Pipeline registers with their valid bits.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            if (can[k]) begin
                r_st[k] <= n_st[k];
            end
        end
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (can[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (can[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Output register: cell centers and signed velocity.
    always_ff @(posedge i_clk) begin
        if (can[NSTAGE]) begin
            o_start_x_fixed <= {r_st[NSTAGE-1].sx, 1'b1, {(FRAC_BITS-1){1'b0}}};
            o_start_y_fixed <= {r_st[NSTAGE-1].sy, 1'b1, {(FRAC_BITS-1){1'b0}}};
            if (r_st[NSTAGE-1].zero) begin
                o_velocity_x <= '0;
                o_velocity_y <= '0;
            end else begin
                o_velocity_x <= r_st[NSTAGE-1].negx ? -VEL_BITS'(r_st[NSTAGE-1].qx)
                                                    : VEL_BITS'(r_st[NSTAGE-1].qx);
                o_velocity_y <= r_st[NSTAGE-1].negy ? -VEL_BITS'(r_st[NSTAGE-1].qy)
                                                    : VEL_BITS'(r_st[NSTAGE-1].qy);
            end
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (can[NSTAGE]) begin
            o_valid <= r_v[NSTAGE-1];
        end
    end

    // Input is held off only when every stage and the output are full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_v) && o_valid && i_stall))
        else $error("input stalled with room in the pipeline");

    // A result leaving the last stage reaches the output register.
    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTAGE-1] && can[NSTAGE]) |=> o_valid)
        else $error("result from last stage was dropped");

    // A full front stage that cannot move keeps its request.
    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !can[1]) |=> (r_v[0] && $stable(r_st[0])))
        else $error("front stage lost a held request");

endmodule

// ----- sim/fixed_point_velocity_from_target_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_velocity_from_target_top_tb: launch vector checker
// Drives source, target and speed requests through the velocity pipeline.
// Each accepted request is turned into an expected start position and
// velocity by a behavioral computation of the root and the truncating
// division, and each returned result is compared with the oldest one.
// ----------------------------------------------------------------------------
module fixed_point_velocity_from_target_top_tb;
    import fpv_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [SPEED_BITS-1:0] speed;
    } t_launch;

    typedef struct packed {
        logic [START_BITS-1:0]      start_x;
        logic [START_BITS-1:0]      start_y;
        logic signed [VEL_BITS-1:0] vel_x;
        logic signed [VEL_BITS-1:0] vel_y;
    } t_vector;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [COORD_BITS-1:0]      i_source_x = '0;
    logic [COORD_BITS-1:0]      i_source_y = '0;
    logic [COORD_BITS-1:0]      i_target_x = '0;
    logic [COORD_BITS-1:0]      i_target_y = '0;
    logic [SPEED_BITS-1:0]      i_speed = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [START_BITS-1:0]      o_start_x_fixed;
    logic [START_BITS-1:0]      o_start_y_fixed;
    logic signed [VEL_BITS-1:0] o_velocity_x;
    logic signed [VEL_BITS-1:0] o_velocity_y;

    t_launch pending_launches[$];
    t_vector expected_vectors[$];
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      hold_off = 1'b0;
    bit      stimulus_done = 1'b0;
    int      mismatch_count = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;

    fixed_point_velocity_from_target_top uut (.*);

    always #4 i_clk = ~i_clk;

    // Floor of the square root, one result bit at a time.
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // One velocity component, truncated toward zero.
    function automatic logic signed [VEL_BITS-1:0] scaled_component(
            int from_c, int to_c, int speed, longint unsigned mag);
        longint unsigned d;
        longint unsigned q;
        if (mag == 0) return '0;
        d = (to_c >= from_c) ? to_c - from_c : from_c - to_c;
        q = ((d << FRAC_BITS) * speed) / mag;
        if (to_c < from_c) q = -q;
        return q[VEL_BITS-1:0];
    endfunction

    function automatic t_vector launch_vector(t_launch l);
        t_vector v;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned mag;
        dx = (l.tx >= l.sx) ? l.tx - l.sx : l.sx - l.tx;
        dy = (l.ty >= l.sy) ? l.ty - l.sy : l.sy - l.ty;
        mag = root_floor((dx * dx + dy * dy) << FRAC_BITS);
        v.start_x = {l.sx, 1'b1, {(FRAC_BITS-1){1'b0}}};
        v.start_y = {l.sy, 1'b1, {(FRAC_BITS-1){1'b0}}};
        v.vel_x = scaled_component(l.sx, l.tx, l.speed, mag);
        v.vel_y = scaled_component(l.sy, l.ty, l.speed, mag);
        return v;
    endfunction

    function automatic t_launch random_launch();
        t_launch l;
        l.sx    = COORD_BITS'($urandom);
        l.sy    = COORD_BITS'($urandom);
        l.tx    = COORD_BITS'($urandom);
        l.ty    = COORD_BITS'($urandom);
        l.speed = SPEED_BITS'($urandom);
        // Short hops now and then, where rounding matters most.
        if ($urandom_range(0, 3) == 0) begin
            l.tx = COORD_BITS'(l.sx + $urandom_range(0, 6) - 3);
            l.ty = COORD_BITS'(l.sy + $urandom_range(0, 6) - 3);
        end
        if ($urandom_range(0, 15) == 0) l.speed = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        return l;
    endfunction

    // Driver: present the next request at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (!hold_off && pending_launches.size() > 0 &&
                        $urandom_range(1, 100) > send_idle_pct) begin
                    i_valid <= 1'b1;
                    {i_source_x, i_source_y, i_target_x, i_target_y, i_speed}
                        <= pending_launches.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
        end
    end

    // Monitor: record accepted requests and check accepted results.
    always @(posedge i_clk) begin
        t_vector exp_v;
        t_vector got_v;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (i_valid && !o_stall) begin
                expected_vectors.push_back(launch_vector(
                    {i_source_x, i_source_y, i_target_x, i_target_y, i_speed}));
            end
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                got_v = {o_start_x_fixed, o_start_y_fixed, o_velocity_x, o_velocity_y};
                if (expected_vectors.size() == 0) begin
                    $display("%0t: expected no result, got %h", $time, got_v);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_v = expected_vectors.pop_front();
                    if (got_v.start_x !== exp_v.start_x ||
                            got_v.start_y !== exp_v.start_y ||
                            got_v.vel_x !== exp_v.vel_x ||
                            got_v.vel_y !== exp_v.vel_y) begin
                        $display("%0t: expected start %h,%h vel %0d,%0d got %h,%h vel %0d,%0d",
                            $time, exp_v.start_x, exp_v.start_y, exp_v.vel_x, exp_v.vel_y,
                            got_v.start_x, got_v.start_y, got_v.vel_x, got_v.vel_y);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d results outstanding", expected_vectors.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_launches.size() > 0 || i_valid || expected_vectors.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        t_launch l;
        int cx;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, same cell, zero and full speed, axis moves.
        pending_launches.push_back({7'd0, 7'd0, 7'd127, 7'd127, 8'd255});
        pending_launches.push_back({7'd127, 7'd127, 7'd0, 7'd0, 8'd255});
        pending_launches.push_back({7'd0, 7'd127, 7'd127, 7'd0, 8'd255});
        pending_launches.push_back({7'd127, 7'd0, 7'd0, 7'd127, 8'd1});
        pending_launches.push_back({7'd64, 7'd64, 7'd64, 7'd64, 8'd255});
        pending_launches.push_back({7'd0, 7'd0, 7'd0, 7'd0, 8'd0});
        pending_launches.push_back({7'd127, 7'd127, 7'd127, 7'd127, 8'd128});
        pending_launches.push_back({7'd10, 7'd20, 7'd90, 7'd5, 8'd0});
        pending_launches.push_back({7'd0, 7'd5, 7'd127, 7'd5, 8'd255});
        pending_launches.push_back({7'd127, 7'd5, 7'd0, 7'd5, 8'd255});
        pending_launches.push_back({7'd5, 7'd0, 7'd5, 7'd127, 8'd255});
        pending_launches.push_back({7'd5, 7'd127, 7'd5, 7'd0, 8'd255});
        pending_launches.push_back({7'd3, 7'd3, 7'd4, 7'd4, 8'd255});
        pending_launches.push_back({7'd3, 7'd3, 7'd2, 7'd4, 8'd1});
        pending_launches.push_back({7'd85, 7'd42, 7'd42, 7'd85, 8'd170});
        pending_launches.push_back({7'd42, 7'd85, 7'd85, 7'd42, 8'd85});
        wait_drained();

        // Random phases; phase 1 holds the sender midway until every result is back.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int n = 0; n < 435; n++) begin
                l = random_launch();
                pending_launches.push_back(l);
            end
            if (phase == 1) begin
                @(posedge i_clk);
                while (pending_launches.size() > 300) @(posedge i_clk);
                hold_off = 1'b1;
                while (i_valid || expected_vectors.size() > 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_drained();
        end

        recv_stall_pct = 0;
        repeat (60) @(posedge i_clk);
        cx = results_seen;
        $display("Checked %0d launch vectors over four handshake pacing phases,", cx);
        $display("including corner, same-cell, zero-speed and short-hop cases.");
        if (mismatch_count == 0 && expected_vectors.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
